FILE: hw/rtl/arm64_jump_stub_resolver_assert.svh
// assertion macros for the jump stub resolver rtl
// no dependencies; included by arm64_jump_stub_resolver.sv, which carries the concurrent checks
`ifndef ARM64_JUMP_STUB_RESOLVER_ASSERT_SVH
`define ARM64_JUMP_STUB_RESOLVER_ASSERT_SVH

// same-cycle implication, disabled while reset is asserted
`define AJSR_ASSERT_IMPL(label, clk, rstn, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (lhs) |-> (rhs)) \
        else $error("ajsr same-cycle check failed");

// next-cycle implication, disabled while reset is asserted
`define AJSR_ASSERT_NEXT(label, clk, rstn, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (lhs) |=> (rhs)) \
        else $error("ajsr next-cycle check failed");

`endif

FILE: hw/rtl/ajsr_pkg.sv
// types and constants for the arm64 jump stub resolver
// no dependencies; imported by every resolver module
`timescale 1ns / 1ps
`default_nettype none

package ajsr_pkg;

    localparam int unsigned ADDR_W  = 64;
    localparam int unsigned WORD_W  = 32;
    localparam int unsigned HOP_W   = 4;

    localparam logic [HOP_W-1:0] HOP_LIMIT_RESET = 4'd5;

    // direct branch
    localparam logic [WORD_W-1:0] B_MASK     = 32'h7C00_0000;
    localparam logic [WORD_W-1:0] B_MATCH    = 32'h1400_0000;
    // ldr xn, #8
    localparam logic [WORD_W-1:0] LDR_MASK   = 32'hFFFF_FFE0;
    localparam logic [WORD_W-1:0] LDR_MATCH  = 32'h5800_0040;
    // br xn
    localparam logic [WORD_W-1:0] BR_BASE    = 32'hD61F_0000;
    // adrp xn
    localparam logic [WORD_W-1:0] ADRP_MASK  = 32'h9F00_0000;
    localparam logic [WORD_W-1:0] ADRP_MATCH = 32'h9000_0000;
    // add xn, xn, #imm12 without shift
    localparam logic [WORD_W-1:0] ADD_MASK   = 32'hFFC0_03E0;
    localparam logic [WORD_W-1:0] ADD_MATCH  = 32'h9100_0000;

    typedef enum logic [1:0] {
        KIND_NONE    = 2'd0,
        KIND_BRANCH  = 2'd1,
        KIND_LITERAL = 2'd2,
        KIND_PAGE    = 2'd3
    } stub_kind_t;

    typedef struct packed {
        stub_kind_t         kind;
        logic [ADDR_W-1:0]  target;
    } dec_res_t;

    typedef struct packed {
        stub_kind_t         kind;
        logic [ADDR_W-1:0]  target;
        logic               done;
    } hop_res_t;

endpackage

`default_nettype wire

FILE: hw/rtl/ajsr_decode.sv
// stub pattern decoder: classifies one hop and computes its target
// depends on ajsr_pkg
`timescale 1ns / 1ps
`default_nettype none

module ajsr_decode
    import ajsr_pkg::*;
(
    input  wire logic [ADDR_W-1:0] pc,
    input  wire logic [WORD_W-1:0] word_zero,
    input  wire logic [WORD_W-1:0] word_one,
    input  wire logic [ADDR_W-1:0] literal_quad,
    output dec_res_t               res
);

    logic [4:0]        rd;
    logic [WORD_W-1:0] word_two;
    logic [WORD_W-1:0] br_word;
    logic              is_branch;
    logic              is_literal;
    logic              is_page;
    logic [ADDR_W-1:0] branch_target;
    logic [20:0]       imm21;
    logic [51:0]       page_hi;

    assign rd       = word_zero[4:0];
    assign word_two = literal_quad[WORD_W-1:0];
    assign br_word  = BR_BASE | {22'd0, rd, 5'd0};

    assign is_branch  = ((word_zero & B_MASK) == B_MATCH) && !word_zero[31];
    assign is_literal = ((word_zero & LDR_MASK) == LDR_MATCH) && (word_one == br_word);
    assign is_page    = ((word_zero & ADRP_MASK) == ADRP_MATCH)
                     && ((word_one & ADD_MASK) == (ADD_MATCH | {22'd0, rd, 5'd0}))
                     && (word_one[4:0] == rd)
                     && (word_two == br_word);

    // pc + sext(imm26) * 4
    assign branch_target = pc + {{36{word_zero[25]}}, word_zero[25:0], 2'b00};

    // page base plus sext(imm21) pages; imm12 fills the cleared low bits
    assign imm21   = {word_zero[23:5], word_zero[30:29]};
    assign page_hi = pc[ADDR_W-1:12] + {{31{imm21[20]}}, imm21};

    always_comb begin
        if (is_branch) begin
            res.kind   = KIND_BRANCH;
            res.target = branch_target;
        end else if (is_literal) begin
            res.kind   = KIND_LITERAL;
            res.target = literal_quad;
        end else if (is_page) begin
            res.kind   = KIND_PAGE;
            res.target = {page_hi, word_one[21:10]};
        end else begin
            res.kind   = KIND_NONE;
            res.target = pc;
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/ajsr_hop_ctrl.sv
// hop limit register, hop counter and final result selection
// depends on ajsr_pkg
`timescale 1ns / 1ps
`default_nettype none

module ajsr_hop_ctrl
    import ajsr_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              cfg_wr_en,
    input  wire logic [HOP_W-1:0]  cfg_wr_data,
    input  wire logic              advance,
    input  wire logic              start_of_chain,
    input  wire logic [ADDR_W-1:0] pc,
    input  wire dec_res_t          dec,
    output hop_res_t               res,
    output logic [HOP_W-1:0]       hops_taken
);

    logic [HOP_W-1:0] hop_limit_reg;
    logic [HOP_W-1:0] hops_reg;
    logic [HOP_W-1:0] hops_next;
    logic [HOP_W-1:0] hops_base;
    logic [HOP_W-1:0] hops_inc;

    assign hops_base = start_of_chain ? '0 : hops_reg;
    assign hops_inc  = hops_base + 4'd1;

    always_comb begin
        hops_next  = hops_base;
        res.kind   = KIND_NONE;
        res.target = pc;
        res.done   = 1'b1;
        if ((hops_base < hop_limit_reg) && (dec.kind != KIND_NONE)) begin
            hops_next  = hops_inc;
            res.kind   = dec.kind;
            res.target = dec.target;
            res.done   = (hops_inc >= hop_limit_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hop_limit_reg <= HOP_LIMIT_RESET;
            hops_reg      <= '0;
        end else begin
            if (cfg_wr_en) begin
                hop_limit_reg <= cfg_wr_data;
            end
            if (advance) begin
                hops_reg <= hops_next;
            end
        end
    end

    assign hops_taken = hops_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/arm64_jump_stub_resolver.sv
// top level of the arm64 jump stub resolver: input register, decode, result register
// depends on ajsr_pkg, ajsr_decode, ajsr_hop_ctrl, arm64_jump_stub_resolver_assert.svh
`timescale 1ns / 1ps
`default_nettype none

// channel   direction  handshake             payload
// s_        in         s_valid / s_ready     start_of_chain, address, two words, quad
// m_        out        m_valid / m_ready     next_address, stub_kind, chain_done
// cfg_      in         cfg_wr_en             cfg_wr_data (hop limit)
//
// two register stages: a hop is captured in the input register, decoded and
// resolved into the result register, one hop per cycle sustained while m_ready stays high
// the hop counter updates as a hop moves from input to result register
// a stall on m_ready holds the result; one more hop may wait in the input register
// synchronous active low reset clears valids, hop counter and hop limit (to 5)

`include "arm64_jump_stub_resolver_assert.svh"

module arm64_jump_stub_resolver
    import ajsr_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    // configuration
    input  wire logic              cfg_wr_en,
    input  wire logic [HOP_W-1:0]  cfg_wr_data,
    // input channel
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire logic              s_start_of_chain,
    input  wire logic [ADDR_W-1:0] s_current_address,
    input  wire logic [WORD_W-1:0] s_word_zero,
    input  wire logic [WORD_W-1:0] s_word_one,
    input  wire logic [ADDR_W-1:0] s_literal_quad,
    // result channel
    output logic                   m_valid,
    input  wire logic              m_ready,
    output logic [ADDR_W-1:0]      m_next_address,
    output logic [1:0]             m_stub_kind,
    output logic                   m_chain_done
);

    // input register
    logic              in_valid_reg;
    logic              in_start_reg;
    logic [ADDR_W-1:0] in_pc_reg;
    logic [WORD_W-1:0] in_w0_reg;
    logic [WORD_W-1:0] in_w1_reg;
    logic [ADDR_W-1:0] in_quad_reg;

    // result register
    logic              out_valid_reg;
    hop_res_t          out_res_reg;

    logic              out_free;
    logic              advance;
    logic              s_xfer;
    dec_res_t          dec_res;
    hop_res_t          hop_res;
    logic [HOP_W-1:0]  hops_taken;

    // result register can take a new hop when empty or being drained this cycle
    assign out_free = !out_valid_reg || m_ready;
    assign advance  = in_valid_reg && out_free;
    // input register can take a transfer when empty or moving forward this cycle
    assign s_ready  = !in_valid_reg || out_free;
    assign s_xfer   = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            in_start_reg <= s_start_of_chain;
            in_pc_reg    <= s_current_address;
            in_w0_reg    <= s_word_zero;
            in_w1_reg    <= s_word_one;
            in_quad_reg  <= s_literal_quad;
        end
    end

    ajsr_decode u_decode (
        .pc           (in_pc_reg),
        .word_zero    (in_w0_reg),
        .word_one     (in_w1_reg),
        .literal_quad (in_quad_reg),
        .res          (dec_res)
    );

    ajsr_hop_ctrl u_hop_ctrl (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .advance        (advance),
        .start_of_chain (in_start_reg),
        .pc             (in_pc_reg),
        .dec            (dec_res),
        .res            (hop_res),
        .hops_taken     (hops_taken)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_res_reg <= hop_res;
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_next_address = out_res_reg.target;
    assign m_stub_kind    = out_res_reg.kind;
    assign m_chain_done   = out_res_reg.done;

    // an unmatched or limited hop always ends the chain
    `AJSR_ASSERT_IMPL(a_none_is_done, aclk, aresetn,
                      m_valid && (m_stub_kind == KIND_NONE), m_chain_done)
    // both stages full and output stalled: no room for another transfer
    `AJSR_ASSERT_IMPL(a_full_blocks, aclk, aresetn,
                      in_valid_reg && m_valid && !m_ready, !s_ready)
    // the hop counter only moves when a hop reaches the result register
    `AJSR_ASSERT_NEXT(a_hops_hold, aclk, aresetn, !advance, $stable(hops_taken))

endmodule

`default_nettype wire

FILE: tb/sv/ajsr_hop_checker.sv
// hop checker for the arm64 jump stub resolver: predicts every hop and compares results
// depends on ajsr_pkg; instantiated beside the block by arm64_jump_stub_resolver_test
`timescale 1ns / 1ps

module ajsr_hop_checker
    import ajsr_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              cfg_wr_en,
    input  wire logic [HOP_W-1:0]  cfg_wr_data,
    input  wire logic              s_valid,
    input  wire logic              s_ready,
    input  wire logic              s_start_of_chain,
    input  wire logic [ADDR_W-1:0] s_current_address,
    input  wire logic [WORD_W-1:0] s_word_zero,
    input  wire logic [WORD_W-1:0] s_word_one,
    input  wire logic [ADDR_W-1:0] s_literal_quad,
    input  wire logic              m_valid,
    input  wire logic              m_ready,
    input  wire logic [ADDR_W-1:0] m_next_address,
    input  wire logic [1:0]        m_stub_kind,
    input  wire logic              m_chain_done,
    output int                     outstanding,
    output int                     mismatches
);

    // opcode patterns, bit31 folded into the branch mask
    localparam logic [31:0] BRANCH_MASK  = 32'hFC00_0000;
    localparam logic [31:0] BRANCH_OPC   = 32'h1400_0000;
    localparam logic [31:0] LITERAL_MASK = 32'hFFFF_FFE0;
    localparam logic [31:0] LITERAL_OPC  = 32'h5800_0040;
    localparam logic [31:0] BR_OPC       = 32'hD61F_0000;
    localparam logic [31:0] PAGE_MASK    = 32'h9F00_0000;
    localparam logic [31:0] PAGE_OPC     = 32'h9000_0000;
    localparam logic [31:0] ADDI_MASK    = 32'hFFC0_03E0;
    localparam logic [31:0] ADDI_OPC     = 32'h9100_0000;

    logic [HOP_W-1:0] hop_limit;
    logic [HOP_W-1:0] hop_count;
    hop_res_t         pending_hops[$];

    function automatic dec_res_t decode_stub(input logic [63:0] pc, input logic [31:0] w0,
                                             input logic [31:0] w1, input logic [63:0] quad);
        dec_res_t    res;
        logic [4:0]  xn;
        logic [31:0] br_word;
        logic [20:0] pages;
        logic [63:0] page_base;
        xn         = w0[4:0];
        br_word    = BR_OPC | {22'd0, xn, 5'd0};
        res.kind   = KIND_NONE;
        res.target = pc;
        if ((w0 & BRANCH_MASK) == BRANCH_OPC) begin
            res.kind   = KIND_BRANCH;
            res.target = pc + {{36{w0[25]}}, w0[25:0], 2'b00};
        end else if ((w0 & LITERAL_MASK) == LITERAL_OPC && w1 == br_word) begin
            res.kind   = KIND_LITERAL;
            res.target = quad;
        end else if ((w0 & PAGE_MASK) == PAGE_OPC &&
                     (w1 & ADDI_MASK) == (ADDI_OPC | {22'd0, xn, 5'd0}) &&
                     w1[4:0] == xn && quad[31:0] == br_word) begin
            pages      = {w0[23:5], w0[30:29]};
            page_base  = {pc[63:12], 12'd0} + {{31{pages[20]}}, pages, 12'd0};
            res.kind   = KIND_PAGE;
            res.target = page_base + {52'd0, w1[21:10]};
        end
        return res;
    endfunction

    always @(posedge aclk) begin : track
        hop_res_t want;
        dec_res_t stub;
        if (!aresetn) begin
            hop_limit = HOP_LIMIT_RESET;
            hop_count = '0;
            pending_hops.delete();
        end else begin
            // results first: a hop taken at this edge cannot leave at it
            if (m_valid && m_ready) begin
                if (pending_hops.size() == 0) begin
                    mismatches++;
                    $display("%0t: result expected none actual %h kind %0d done %0d",
                             $time, m_next_address, m_stub_kind, m_chain_done);
                end else begin
                    want = pending_hops.pop_front();
                    if (m_next_address !== want.target) begin
                        mismatches++;
                        $display("%0t: next_address expected %h actual %h",
                                 $time, want.target, m_next_address);
                    end
                    if (m_stub_kind !== want.kind) begin
                        mismatches++;
                        $display("%0t: stub_kind expected %0d actual %0d",
                                 $time, want.kind, m_stub_kind);
                    end
                    if (m_chain_done !== want.done) begin
                        mismatches++;
                        $display("%0t: chain_done expected %0d actual %0d",
                                 $time, want.done, m_chain_done);
                    end
                end
            end
            if (cfg_wr_en) begin
                hop_limit = cfg_wr_data;
            end
            if (s_valid && s_ready) begin
                if (s_start_of_chain) begin
                    hop_count = '0;
                end
                want.kind   = KIND_NONE;
                want.target = s_current_address;
                want.done   = 1'b1;
                // at the limit the words are not looked at and the count holds
                if (hop_count < hop_limit) begin
                    stub = decode_stub(s_current_address, s_word_zero, s_word_one,
                                       s_literal_quad);
                    if (stub.kind != KIND_NONE) begin
                        hop_count   = hop_count + 1'b1;
                        want.kind   = stub.kind;
                        want.target = stub.target;
                        want.done   = (hop_count >= hop_limit);
                    end
                end
                pending_hops.push_back(want);
            end
        end
        outstanding <= pending_hops.size();
    end

endmodule

FILE: tb/sv/arm64_jump_stub_resolver_test.sv
// top of the jump stub resolver testbench: clock, reset, stimulus and verdict
// depends on ajsr_pkg, arm64_jump_stub_resolver and ajsr_hop_checker
`timescale 1ns / 1ps

module arm64_jump_stub_resolver_test;
    import ajsr_pkg::*;

    // percent of cycles in which a side holds back
    localparam int unsigned IDLE_PCT    = 29;
    localparam int unsigned PHASE_ITEMS = 76;
    localparam int unsigned PHASES      = 7;
    // hop limit per random phase, phase 0 in the lowest nibble
    localparam logic [4*PHASES-1:0] PHASE_LIMITS =
        {4'd5, 4'd2, 4'd9, 4'd3, 4'd0, 4'd1, 4'd15};
    // timeout in ns, set far beyond the slowest correct run
    localparam int unsigned TIMEOUT_NS  = 400_000;

    // instruction encodings used to build stubs
    localparam logic [31:0] OPC_B        = 32'h1400_0000;
    localparam logic [31:0] OPC_LDR_LIT8 = 32'h5800_0040;
    localparam logic [31:0] OPC_BR       = 32'hD61F_0000;
    localparam logic [31:0] OPC_ADRP     = 32'h9000_0000;
    localparam logic [31:0] OPC_ADD_X    = 32'h9100_0000;
    localparam int unsigned ADD_SHIFT_BIT = 22;
    localparam int unsigned LINK_BIT      = 31;

    typedef struct packed {
        logic              start;
        logic [ADDR_W-1:0] pc;
        logic [WORD_W-1:0] w0;
        logic [WORD_W-1:0] w1;
        logic [ADDR_W-1:0] quad;
    } hop_req_t;

    logic              aclk;
    logic              aresetn           = 1'b0;
    logic              cfg_wr_en         = 1'b0;
    logic [HOP_W-1:0]  cfg_wr_data       = '0;
    logic              s_valid           = 1'b0;
    logic              s_ready;
    logic              s_start_of_chain  = 1'b0;
    logic [ADDR_W-1:0] s_current_address = '0;
    logic [WORD_W-1:0] s_word_zero       = '0;
    logic [WORD_W-1:0] s_word_one        = '0;
    logic [ADDR_W-1:0] s_literal_quad    = '0;
    logic              m_valid;
    logic              m_ready           = 1'b0;
    logic [ADDR_W-1:0] m_next_address;
    logic [1:0]        m_stub_kind;
    logic              m_chain_done;

    // high during the stretch where neither side idles
    logic              steady            = 1'b0;
    int                outstanding;
    int                mismatches;

    always begin
        aclk = 1'b0;
        #1;
        aclk = 1'b1;
        #1;
    end

    arm64_jump_stub_resolver uut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_wr_data       (cfg_wr_data),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_start_of_chain  (s_start_of_chain),
        .s_current_address (s_current_address),
        .s_word_zero       (s_word_zero),
        .s_word_one        (s_word_one),
        .s_literal_quad    (s_literal_quad),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_next_address    (m_next_address),
        .m_stub_kind       (m_stub_kind),
        .m_chain_done      (m_chain_done)
    );

    ajsr_hop_checker u_checker (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_wr_data       (cfg_wr_data),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_start_of_chain  (s_start_of_chain),
        .s_current_address (s_current_address),
        .s_word_zero       (s_word_zero),
        .s_word_one        (s_word_one),
        .s_literal_quad    (s_literal_quad),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_next_address    (m_next_address),
        .m_stub_kind       (m_stub_kind),
        .m_chain_done      (m_chain_done),
        .outstanding       (outstanding),
        .mismatches        (mismatches)
    );

    // result side backpressure
    always @(posedge aclk) begin
        m_ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    // addresses lean toward zero, all ones and the top of a page
    function automatic logic [63:0] rand_addr();
        logic [63:0] a;
        case ($urandom_range(0, 7))
            0:       a = '0;
            1:       a = '1;
            2:       a = {$urandom, 20'hFFFFF, 12'hFFC};
            default: a = {$urandom, $urandom};
        endcase
        return a;
    endfunction

    // b imm26
    function automatic hop_req_t direct_branch(input logic start, input logic [63:0] pc,
                                               input logic [25:0] offset);
        hop_req_t h;
        h.start = start;
        h.pc    = pc;
        h.w0    = OPC_B | {6'd0, offset};
        h.w1    = $urandom;
        h.quad  = {$urandom, $urandom};
        return h;
    endfunction

    // ldr xn, #8 ; br xn ; .quad target
    function automatic hop_req_t literal_stub(input logic start, input logic [63:0] pc,
                                              input logic [4:0] xn, input logic [63:0] target);
        hop_req_t h;
        h.start = start;
        h.pc    = pc;
        h.w0    = OPC_LDR_LIT8 | {27'd0, xn};
        h.w1    = OPC_BR | {22'd0, xn, 5'd0};
        h.quad  = target;
        return h;
    endfunction

    // adrp xn, pages ; add xn, xn, #offset ; br xn
    function automatic hop_req_t page_thunk(input logic start, input logic [63:0] pc,
                                            input logic [4:0] xn, input logic [20:0] pages,
                                            input logic [11:0] offset);
        hop_req_t h;
        h.start = start;
        h.pc    = pc;
        h.w0    = OPC_ADRP | {1'b0, pages[1:0], 5'd0, pages[20:2], xn};
        h.w1    = OPC_ADD_X | {10'd0, offset, xn, xn};
        h.quad  = {$urandom, OPC_BR | {22'd0, xn, 5'd0}};
        return h;
    endfunction

    // near misses: single bit flips, shifted add, flipped bit 31 (the link bit on a branch)
    function automatic hop_req_t spoil(input hop_req_t h);
        hop_req_t bad;
        bad = h;
        case ($urandom_range(0, 4))
            0:       bad.w0 = bad.w0 ^ (32'd1 << $urandom_range(0, 31));
            1:       bad.w1 = bad.w1 ^ (32'd1 << $urandom_range(0, 31));
            2:       bad.quad = bad.quad ^ (64'd1 << $urandom_range(0, 31));
            3:       bad.w1[ADD_SHIFT_BIT] = 1'b1;
            default: bad.w0[LINK_BIT] = ~bad.w0[LINK_BIT];
        endcase
        return bad;
    endfunction

    // mostly well-formed stubs with random content, some spoiled, some pure noise
    function automatic hop_req_t random_hop();
        hop_req_t    h;
        int unsigned pick;
        case ($urandom_range(0, 2))
            0:       h = direct_branch(1'b0, rand_addr(), 26'($urandom));
            1:       h = literal_stub(1'b0, rand_addr(), 5'($urandom), {$urandom, $urandom});
            default: h = page_thunk(1'b0, rand_addr(), 5'($urandom), 21'($urandom),
                                    12'($urandom));
        endcase
        pick = $urandom_range(0, 99);
        if (pick < 15) begin
            h = spoil(h);
        end else if (pick < 22) begin
            h.w0   = $urandom;
            h.w1   = $urandom;
            h.quad = {$urandom, $urandom};
        end
        return h;
    endfunction

    // one transfer on the input channel; valid only drops when this side idles
    task automatic send_hop(input hop_req_t h);
        while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid           <= 1'b1;
        s_start_of_chain  <= h.start;
        s_current_address <= h.pc;
        s_word_zero       <= h.w0;
        s_word_one        <= h.w1;
        s_literal_quad    <= h.quad;
        @(posedge aclk);
        while (!s_ready) begin
            @(posedge aclk);
        end
    endtask

    // stop sending and wait until every predicted result has come back
    task automatic drain_hops();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) begin
            @(posedge aclk);
        end
    endtask

    task automatic load_hop_limit(input logic [HOP_W-1:0] limit);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= limit;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    // chains mostly open with start_of_chain and run up to three hops past the limit
    task automatic run_chains(input int unsigned count, input int limit);
        hop_req_t    h;
        int unsigned sent;
        int unsigned len;
        int unsigned k;
        sent = 0;
        while (sent < count) begin
            len = $urandom_range(1, limit + 3);
            for (k = 0; k < len && sent < count; k++) begin
                h = random_hop();
                if (k == 0) begin
                    h.start = ($urandom_range(0, 9) != 0);
                end else begin
                    h.start = ($urandom_range(0, 19) == 0);
                end
                send_hop(h);
                sent++;
            end
        end
    endtask

    initial begin
        hop_req_t h;
        int       ph;
        int       i;

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // directed hops under the reset limit of five
        // branch extremes: largest forward reach, most negative reach wrapping below zero
        send_hop(direct_branch(1'b1, 64'h0000_0000_0040_0000, 26'h1FF_FFFF));
        send_hop(direct_branch(1'b0, 64'h0, 26'h200_0000));
        // branch with link is not a stub
        h = direct_branch(1'b0, rand_addr(), 26'($urandom));
        h.w0[LINK_BIT] = 1'b1;
        send_hop(h);
        // literal stub, target all ones
        send_hop(literal_stub(1'b1, 64'hFFFF_FFFF_FFFF_FFFC, 5'd17, '1));
        // br of another register
        h = literal_stub(1'b0, rand_addr(), 5'd0, {$urandom, $urandom});
        h.w1[9:5] = 5'd1;
        send_hop(h);
        // literal offset other than eight
        h = literal_stub(1'b0, rand_addr(), 5'd31, {$urandom, $urandom});
        h.w0[5] = 1'b1;
        send_hop(h);
        // page thunk extremes: top page forward, bottom page backward
        send_hop(page_thunk(1'b1, 64'hFFFF_FFFF_FFFF_FFFF, 5'd16, 21'h0F_FFFF, 12'hFFF));
        send_hop(page_thunk(1'b0, 64'h0, 5'd31, 21'h10_0000, 12'h000));
        // shifted add does not count
        h = page_thunk(1'b1, rand_addr(), 5'd16, 21'($urandom), 12'($urandom));
        h.w1[ADD_SHIFT_BIT] = 1'b1;
        send_hop(h);
        // add reading another register
        h = page_thunk(1'b0, rand_addr(), 5'd9, 21'($urandom), 12'($urandom));
        h.w1[9:5] = 5'd22;
        send_hop(h);
        // add writing another register
        h = page_thunk(1'b0, rand_addr(), 5'd9, 21'($urandom), 12'($urandom));
        h.w1[4:0] = 5'd3;
        send_hop(h);
        // third word branches through another register
        h = page_thunk(1'b0, rand_addr(), 5'd2, 21'($urandom), 12'($urandom));
        h.quad[5] = ~h.quad[5];
        send_hop(h);
        // six branches in one chain: the fifth reaches the limit, the sixth is refused
        for (i = 0; i < 6; i++) begin
            send_hop(direct_branch(i == 0, rand_addr(), 26'($urandom)));
        end
        // all zero and all one fields
        send_hop('{start: 1'b1, pc: '0, w0: '0, w1: '0, quad: '0});
        send_hop('{start: 1'b1, pc: '1, w0: '1, w1: '1, quad: '1});
        send_hop(literal_stub(1'b0, rand_addr(), 5'd30, {$urandom, $urandom}));

        // random phases, each under its own hop limit, written while idle
        for (ph = 0; ph < PHASES; ph++) begin
            drain_hops();
            load_hop_limit(PHASE_LIMITS[4*ph +: 4]);
            steady <= (ph == 0);
            run_chains(PHASE_ITEMS, int'(PHASE_LIMITS[4*ph +: 4]));
        end

        drain_hops();
        steady <= 1'b0;
        // catch stray results after the last expected one
        repeat (10) @(posedge aclk);
        if (mismatches == 0) begin
            $display("arm64_jump_stub_resolver_test: PASS");
        end else begin
            $display("arm64_jump_stub_resolver_test: FAIL");
        end
        $finish;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("arm64_jump_stub_resolver_test: FAIL");
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+hw/rtl
hw/rtl/ajsr_pkg.sv
hw/rtl/ajsr_decode.sv
hw/rtl/ajsr_hop_ctrl.sv
hw/rtl/arm64_jump_stub_resolver.sv
tb/sv/ajsr_hop_checker.sv
tb/sv/arm64_jump_stub_resolver_test.sv
